/* sv/gvsn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid vertex star package
// Shared widths, register indexes, the Freudenthal offset table and the
// request type handed from the index pipeline to the result sequencer.
// ----------------------------------------------------------------------------
package gvsn_pkg;

    localparam int STAR_SIZE     = 14;
    localparam int SLOT_W        = 4;
    localparam int IDX_W         = 30;
    localparam int CFG_W         = 11;
    localparam int REG_IDX_W     = 2;
    localparam int DEF_DIM_BITS  = 10;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DIM_X = 2'd0,
        REG_DIM_Y = 2'd1,
        REG_DIM_Z = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OFF_NEG,
        OFF_ZERO,
        OFF_POS
    } off_t;

    typedef struct packed {
        off_t dx;
        off_t dy;
        off_t dz;
    } star_off_t;

    typedef struct packed {
        logic             vld;
        logic             nul;
        logic [STAR_SIZE-1:0] mask;
        logic [IDX_W-1:0] base_zm;
        logic [IDX_W-1:0] base_z0;
        logic [IDX_W-1:0] base_zp;
    } star_item_t;

    localparam off_t STAR_DX [STAR_SIZE] = '{
        OFF_NEG,  OFF_ZERO, OFF_NEG,  OFF_ZERO, OFF_NEG,  OFF_ZERO, OFF_NEG,
        OFF_POS,  OFF_ZERO, OFF_POS,  OFF_ZERO, OFF_POS,  OFF_ZERO, OFF_POS
    };
    localparam off_t STAR_DY [STAR_SIZE] = '{
        OFF_NEG,  OFF_NEG,  OFF_ZERO, OFF_ZERO, OFF_NEG,  OFF_NEG,  OFF_ZERO,
        OFF_ZERO, OFF_POS,  OFF_POS,  OFF_ZERO, OFF_ZERO, OFF_POS,  OFF_POS
    };
    localparam off_t STAR_DZ [STAR_SIZE] = '{
        OFF_NEG,  OFF_NEG,  OFF_NEG,  OFF_NEG,  OFF_ZERO, OFF_ZERO, OFF_ZERO,
        OFF_ZERO, OFF_ZERO, OFF_ZERO, OFF_POS,  OFF_POS,  OFF_POS,  OFF_POS
    };

    function automatic star_off_t star_offset(input logic [SLOT_W-1:0] slot);
        star_off_t res;
        res = '{dx: OFF_ZERO, dy: OFF_ZERO, dz: OFF_ZERO};
        if (slot < SLOT_W'(STAR_SIZE))
        begin
            res.dx = STAR_DX[slot];
            res.dy = STAR_DY[slot];
            res.dz = STAR_DZ[slot];
        end
        return res;
    endfunction

    function automatic logic off_ok(input off_t o, input logic lo_ok, input logic hi_ok);
        logic res;
        case (o)
            OFF_NEG:  res = lo_ok;
            OFF_POS:  res = hi_ok;
            default:  res = 1'b1;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

/* sv/gvsn_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid vertex star configuration
// Holds the three dimension registers, clamps them to the supported range
// and keeps the registered plane and volume products used by the pipeline.
// ----------------------------------------------------------------------------
module gvsn_cfg #(
    parameter int DIM_BITS = gvsn_pkg::DEF_DIM_BITS,
    parameter int DMW      = (DIM_BITS < gvsn_pkg::CFG_W) ? DIM_BITS + 1 : gvsn_pkg::CFG_W
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [gvsn_pkg::REG_IDX_W-1:0]   wr_index,
    input  logic [gvsn_pkg::CFG_W-1:0]       wr_data,
    output logic [DMW-1:0]                   nx,
    output logic [DMW-1:0]                   ny,
    output logic [DMW-1:0]                   nz,
    output logic [2*DMW-1:0]                 plane,
    output logic [3*DMW-1:0]                 total,
    output logic                             settling
);

    localparam int CAP    = 1 << DIM_BITS;
    localparam int SETTLE = 2;

    logic [gvsn_pkg::CFG_W-1:0] dim_x_reg;
    logic [gvsn_pkg::CFG_W-1:0] dim_y_reg;
    logic [gvsn_pkg::CFG_W-1:0] dim_z_reg;
    logic [1:0]                 settle_reg;
    logic [1:0]                 settle_next;
    logic [2*DMW-1:0]           plane_reg;
    logic [3*DMW-1:0]           total_reg;

    function automatic logic [DMW-1:0] eff_dim(input logic [gvsn_pkg::CFG_W-1:0] d);
        logic [DMW-1:0] res;
        if (d == '0)
        begin
            res = DMW'(1);
        end
        else if (int'(d) > CAP)
        begin
            res = DMW'(CAP);
        end
        else
        begin
            res = DMW'(d);
        end
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg  <= gvsn_pkg::CFG_W'(1);
            dim_y_reg  <= gvsn_pkg::CFG_W'(1);
            dim_z_reg  <= gvsn_pkg::CFG_W'(1);
            settle_reg <= 2'(SETTLE);
        end
        else
        begin
            settle_reg <= settle_next;
            if (wr_en)
            begin
                case (wr_index)
                    gvsn_pkg::REG_DIM_X: dim_x_reg <= wr_data;
                    gvsn_pkg::REG_DIM_Y: dim_y_reg <= wr_data;
                    gvsn_pkg::REG_DIM_Z: dim_z_reg <= wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (wr_en)
        begin
            settle_next = 2'(SETTLE);
        end
        else if (settle_reg != 2'd0)
        begin
            settle_next = settle_reg - 2'd1;
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    assign nx = eff_dim(dim_x_reg);
    assign ny = eff_dim(dim_y_reg);
    assign nz = eff_dim(dim_z_reg);

    always_ff @(posedge clk)
    begin
        plane_reg <= (2*DMW)'(nx) * (2*DMW)'(ny);
        total_reg <= (3*DMW)'(plane_reg) * (3*DMW)'(nz);
    end

    assign plane    = plane_reg;
    assign total    = total_reg;
    assign settling = (settle_reg != 2'd0);

endmodule
`default_nettype wire

/* sv/gvsn_div_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid vertex star division step
// One registered restoring division step: tries the shifted divisor against
// the partial remainder and sets one quotient bit. Stalls with the pipeline.
// ----------------------------------------------------------------------------
module gvsn_div_stage #(
    parameter int RW    = 30,
    parameter int DW    = 22,
    parameter int QW    = 10,
    parameter int SHIFT = 0,
    parameter int SW    = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [RW-1:0] in_rem,
    input  logic [QW-1:0] in_quo,
    input  logic [SW-1:0] in_side,
    input  logic [DW-1:0] divisor,
    output logic          out_vld,
    output logic [RW-1:0] out_rem,
    output logic [QW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    localparam int TRW  = DW + SHIFT;
    localparam int CMPW = (TRW > RW) ? TRW : RW;

    logic [CMPW-1:0] rem_ext;
    logic [CMPW-1:0] trial;
    logic            ge;
    logic [RW-1:0]   rem_next;
    logic [QW-1:0]   quo_next;
    logic            vld_reg;
    logic [RW-1:0]   rem_reg;
    logic [QW-1:0]   quo_reg;
    logic [SW-1:0]   side_reg;

    always_comb
    begin
        rem_ext         = CMPW'(in_rem);
        trial           = CMPW'(divisor) << SHIFT;
        ge              = (rem_ext >= trial);
        rem_next        = ge ? RW'(rem_ext - trial) : in_rem;
        quo_next        = in_quo;
        quo_next[SHIFT] = ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_vld  = vld_reg;
    assign out_rem  = rem_reg;
    assign out_quo  = quo_reg;
    assign out_side = side_reg;

endmodule
`default_nettype wire

/* sv/gvsn_emit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid vertex star result sequencer
// Walks the in-bounds offsets of one vertex, lowest slot first, and presents one
// neighbor index per cycle on registered result outputs; a null vertex gives one empty result.
// ----------------------------------------------------------------------------
module gvsn_emit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gvsn_pkg::star_item_t               item,
    input  logic [gvsn_pkg::IDX_W-1:0]         step_y,
    output logic                               ready,
    output logic                               strobe,
    output logic [gvsn_pkg::IDX_W-1:0]         neighbor_index,
    output logic [gvsn_pkg::SLOT_W-1:0]        neighbor_slot,
    output logic                               valid_res,
    output logic                               last
);

    logic                              active_reg;
    logic                              active_next;
    logic                              nul_reg;
    logic [gvsn_pkg::STAR_SIZE-1:0]    mask_reg;
    logic [gvsn_pkg::IDX_W-1:0]        bzm_reg;
    logic [gvsn_pkg::IDX_W-1:0]        bz0_reg;
    logic [gvsn_pkg::IDX_W-1:0]        bzp_reg;
    logic                              strobe_reg;
    logic [gvsn_pkg::IDX_W-1:0]        index_reg;
    logic [gvsn_pkg::SLOT_W-1:0]       slot_reg;
    logic                              valid_reg;
    logic                              last_reg;

    logic [gvsn_pkg::SLOT_W-1:0]       pick;
    logic [gvsn_pkg::STAR_SIZE-1:0]    rest;
    logic                              done_now;
    logic                              load;
    gvsn_pkg::star_off_t               off;
    logic [gvsn_pkg::IDX_W-1:0]        base;
    logic [gvsn_pkg::IDX_W-1:0]        term_y;
    logic [gvsn_pkg::IDX_W-1:0]        term_x;
    logic [gvsn_pkg::IDX_W-1:0]        sum;

    always_comb
    begin
        pick = '0;
        for (int i = gvsn_pkg::STAR_SIZE - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick = gvsn_pkg::SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        rest        = mask_reg & (mask_reg - gvsn_pkg::STAR_SIZE'(1));
        done_now    = active_reg && (nul_reg || (rest == '0));
        ready       = !active_reg || done_now;
        load        = item.vld && ready;
        active_next = load ? 1'b1 : (done_now ? 1'b0 : active_reg);
    end

    always_comb
    begin
        off = gvsn_pkg::star_offset(pick);
        case (off.dz)
            gvsn_pkg::OFF_NEG: base = bzm_reg;
            gvsn_pkg::OFF_POS: base = bzp_reg;
            default:           base = bz0_reg;
        endcase
        case (off.dy)
            gvsn_pkg::OFF_NEG: term_y = gvsn_pkg::IDX_W'(0) - step_y;
            gvsn_pkg::OFF_POS: term_y = step_y;
            default:           term_y = '0;
        endcase
        case (off.dx)
            gvsn_pkg::OFF_NEG: term_x = '1;
            gvsn_pkg::OFF_POS: term_x = gvsn_pkg::IDX_W'(1);
            default:           term_x = '0;
        endcase
        sum = base + term_y + term_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            nul_reg  <= item.nul;
            mask_reg <= item.mask;
            bzm_reg  <= item.base_zm;
            bz0_reg  <= item.base_z0;
            bzp_reg  <= item.base_zp;
        end
        else if (active_reg)
        begin
            mask_reg <= rest;
        end
        index_reg <= nul_reg ? '0 : sum;
        slot_reg  <= nul_reg ? '0 : pick;
        valid_reg <= !nul_reg;
        last_reg  <= done_now;
    end

    assign strobe         = strobe_reg;
    assign neighbor_index = index_reg;
    assign neighbor_slot  = slot_reg;
    assign valid_res      = valid_reg;
    assign last           = last_reg;

    a_null_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !valid_reg |-> last_reg && (index_reg == '0) && (slot_reg == '0))
        else $error("empty result not marked last or not cleared");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> active_reg && !nul_reg == !$past(item.nul))
        else $error("request not taken by sequencer");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && !done_now |=> strobe_reg && !last_reg && active_reg)
        else $error("sequence ended early");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && valid_reg |-> slot_reg < gvsn_pkg::SLOT_W'(gvsn_pkg::STAR_SIZE))
        else $error("slot out of range");

endmodule
`default_nettype wire

/* sv/grid_vertex_star_neighbors_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid vertex star neighbors core
// Splits a linear vertex index into grid coordinates and lists the linear
// indices of its in-bounds Freudenthal star neighbors.
//
// Configure dim_x, dim_y and dim_z through wr_en, wr_index and wr_data while
// the block is idle. A request is taken at a clock edge where start is high
// and busy is low. Each result is shown for one cycle with strobe high;
// the final result of a vertex has last high. A vertex beyond the grid, or
// one with no neighbors, gives a single result with valid_res low.
// A request passes a range-check register, C stages of the z division, C
// stages of the y division and one stage of bounds masks, where C is
// DIM_BITS for DIM_BITS up to 10 and 11 above. A vertex with k in-bounds
// neighbors then gives max(k,1) results, up to 14, on the single result
// port, and results of successive vertices follow back to back. The
// pipeline freezes and busy rises while a prepared vertex waits for the
// occupied result sequencer. busy is also high after reset and after each
// register write, while the plane and volume products settle. Results
// cannot be held off.
// ----------------------------------------------------------------------------
module grid_vertex_star_neighbors_core #(
    parameter int DIM_BITS = gvsn_pkg::DEF_DIM_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [gvsn_pkg::IDX_W-1:0]         vertex_index,
    input  logic                               wr_en,
    input  logic [gvsn_pkg::REG_IDX_W-1:0]     wr_index,
    input  logic [gvsn_pkg::CFG_W-1:0]         wr_data,
    output logic                               strobe,
    output logic [gvsn_pkg::IDX_W-1:0]         neighbor_index,
    output logic [gvsn_pkg::SLOT_W-1:0]        neighbor_slot,
    output logic                               valid_res,
    output logic                               last
);

    localparam int IW   = gvsn_pkg::IDX_W;
    localparam int DMW  = (DIM_BITS < gvsn_pkg::CFG_W) ? DIM_BITS + 1 : gvsn_pkg::CFG_W;
    localparam int CW   = (DIM_BITS < gvsn_pkg::CFG_W) ? DIM_BITS : gvsn_pkg::CFG_W;
    localparam int PW   = 2 * DMW;
    localparam int TW   = 3 * DMW;
    localparam int CMPW = (TW > IW) ? TW : IW;
    localparam int ZSW  = 1 + IW;
    localparam int YSW  = ZSW + CW;

    logic [DMW-1:0] nx;
    logic [DMW-1:0] ny;
    logic [DMW-1:0] nz;
    logic [PW-1:0]  plane;
    logic [TW-1:0]  total;
    logic           settling;

    logic           stall;
    logic           adv;
    logic           accept;
    logic           emit_ready;

    logic           s0_vld_reg;
    logic [IW-1:0]  s0_v_reg;
    logic           s0_oob_reg;

    logic           zv   [0:CW];
    logic [IW-1:0]  zrem [0:CW];
    logic [CW-1:0]  zquo [0:CW];
    logic [ZSW-1:0] zside[0:CW];

    logic           yv   [0:CW];
    logic [PW-1:0]  yrem [0:CW];
    logic [CW-1:0]  yquo [0:CW];
    logic [YSW-1:0] yside[0:CW];

    logic [CW-1:0]                   px;
    logic [CW-1:0]                   py;
    logic [CW-1:0]                   pz;
    logic [IW-1:0]                   pv;
    logic                            poob;
    logic [gvsn_pkg::STAR_SIZE-1:0]  pmask;
    gvsn_pkg::star_off_t             poff;
    gvsn_pkg::star_item_t            prep_next;
    gvsn_pkg::star_item_t            prep_reg;
    logic                            prep_vld_reg;
    gvsn_pkg::star_item_t            emit_item;

    gvsn_cfg #(
        .DIM_BITS (DIM_BITS),
        .DMW      (DMW)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .nx       (nx),
        .ny       (ny),
        .nz       (nz),
        .plane    (plane),
        .total    (total),
        .settling (settling)
    );

    assign stall  = prep_vld_reg && !emit_ready;
    assign adv    = !stall;
    assign busy   = stall || settling;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_v_reg   <= vertex_index;
            s0_oob_reg <= (CMPW'(vertex_index) >= CMPW'(total));
        end
    end

    assign zv[0]    = s0_vld_reg;
    assign zrem[0]  = s0_v_reg;
    assign zquo[0]  = '0;
    assign zside[0] = {s0_oob_reg, s0_v_reg};

    for (genvar i = 0; i < CW; i++)
    begin : g_zdiv
        gvsn_div_stage #(
            .RW    (IW),
            .DW    (PW),
            .QW    (CW),
            .SHIFT (CW - 1 - i),
            .SW    (ZSW)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .in_vld   (zv[i]),
            .in_rem   (zrem[i]),
            .in_quo   (zquo[i]),
            .in_side  (zside[i]),
            .divisor  (plane),
            .out_vld  (zv[i+1]),
            .out_rem  (zrem[i+1]),
            .out_quo  (zquo[i+1]),
            .out_side (zside[i+1])
        );
    end

    assign yv[0]    = zv[CW];
    assign yrem[0]  = PW'(zrem[CW]);
    assign yquo[0]  = '0;
    assign yside[0] = {zside[CW], zquo[CW]};

    for (genvar i = 0; i < CW; i++)
    begin : g_ydiv
        gvsn_div_stage #(
            .RW    (PW),
            .DW    (DMW),
            .QW    (CW),
            .SHIFT (CW - 1 - i),
            .SW    (YSW)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .in_vld   (yv[i]),
            .in_rem   (yrem[i]),
            .in_quo   (yquo[i]),
            .in_side  (yside[i]),
            .divisor  (nx),
            .out_vld  (yv[i+1]),
            .out_rem  (yrem[i+1]),
            .out_quo  (yquo[i+1]),
            .out_side (yside[i+1])
        );
    end

    always_comb
    begin
        px   = CW'(yrem[CW]);
        py   = yquo[CW];
        pz   = yside[CW][CW-1:0];
        pv   = yside[CW][CW+IW-1:CW];
        poob = yside[CW][YSW-1];
        poff = '{dx: gvsn_pkg::OFF_ZERO, dy: gvsn_pkg::OFF_ZERO, dz: gvsn_pkg::OFF_ZERO};
        for (int s = 0; s < gvsn_pkg::STAR_SIZE; s++)
        begin
            poff     = gvsn_pkg::star_offset(gvsn_pkg::SLOT_W'(s));
            pmask[s] = gvsn_pkg::off_ok(poff.dx, px != '0, DMW'(px) != nx - DMW'(1))
                     & gvsn_pkg::off_ok(poff.dy, py != '0, DMW'(py) != ny - DMW'(1))
                     & gvsn_pkg::off_ok(poff.dz, pz != '0, DMW'(pz) != nz - DMW'(1));
        end
        prep_next.vld     = yv[CW];
        prep_next.nul     = poob || (pmask == '0);
        prep_next.mask    = pmask;
        prep_next.base_zm = pv - IW'(plane);
        prep_next.base_z0 = pv;
        prep_next.base_zp = pv + IW'(plane);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            prep_vld_reg <= yv[CW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_reg <= prep_next;
        end
    end

    always_comb
    begin
        emit_item     = prep_reg;
        emit_item.vld = prep_vld_reg;
    end

    gvsn_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (emit_item),
        .step_y         (IW'(nx)),
        .ready          (emit_ready),
        .strobe         (strobe),
        .neighbor_index (neighbor_index),
        .neighbor_slot  (neighbor_slot),
        .valid_res      (valid_res),
        .last           (last)
    );

endmodule
`default_nettype wire
